>>> rtl/srlq_pkg.sv
// Package for the shared/exclusive row lock queue.
// Holds sizes, status and mode codes, command structs and the conflict check.
// No dependencies.
package srlq_pkg;

  localparam int OWNER_SLOTS  = 16;
  localparam int WAITER_SLOTS = 16;
  localparam int MAX_WAKES    = 16;

  localparam int ID_W   = 16;
  localparam int OIDX_W = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int OCNT_W = $clog2(OWNER_SLOTS + 1);
  localparam int WIDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int WCNT_W = $clog2(WAITER_SLOTS + 1);
  localparam int WAKE_W = $clog2(MAX_WAKES + 1);

  // result status codes
  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_ABORT    = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_WOKEN    = 3'd4;
  localparam logic [2:0] ST_NOT_OWN  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // request function codes
  localparam logic FN_ACQUIRE = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  // requester kinds
  localparam logic KIND_DET = 1'b0;
  localparam logic KIND_OPT = 1'b1;

  // held lock modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_SHARED = 2'd1;
  localparam logic [1:0] MODE_EXCL   = 2'd2;

  typedef struct packed {
    logic            ex;
    logic [ID_W-1:0] id;
  } waiter_t;

  typedef struct packed {
    logic              add;
    logic [ID_W-1:0]   add_id;
    logic              remove;
    logic [OIDX_W-1:0] rm_idx;
  } own_cmd_t;

  typedef struct packed {
    logic    push;
    waiter_t push_entry;
    logic    pop;
  } wq_cmd_t;

  // shared wants only a non-exclusive hold; exclusive wants no hold at all
  function automatic logic mode_conflicts(logic [1:0] held, logic ex);
    logic c;
    if (held == MODE_NONE) c = 1'b0;
    else if (held == MODE_SHARED) c = ex;
    else c = 1'b1;
    return c;
  endfunction

endpackage

>>> rtl/srlq_if.sv
// Valid/ready channel interfaces for lock requests and lock results.
// Depends on srlq_pkg for field widths.
interface srlq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [srlq_pkg::ID_W-1:0]   txn_id;
  logic                        want_exclusive;
  logic                        requester_kind;
  logic                        is_recon;
  modport source (output valid, func, txn_id, want_exclusive, requester_kind, is_recon,
                  input ready);
  modport sink (input valid, func, txn_id, want_exclusive, requester_kind, is_recon,
                output ready);
endinterface

interface srlq_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [srlq_pkg::ID_W-1:0] subject_txn;
  logic                      subject_exclusive;
  logic                      last;
  modport source (output valid, status, subject_txn, subject_exclusive, last, input ready);
  modport sink (input valid, status, subject_txn, subject_exclusive, last, output ready);
endinterface

>>> rtl/srlq_owner.sv
// Owner set: slot ids, valid bits, count, and the shared id comparator.
// Depends on srlq_pkg.
module srlq_owner (
  input  logic                            clk,
  input  logic                            rst,
  input  srlq_pkg::own_cmd_t              cmd,
  input  logic [srlq_pkg::OIDX_W-1:0]     scan_idx,
  input  logic [srlq_pkg::ID_W-1:0]       scan_id,
  output logic                            scan_hit,
  output logic [srlq_pkg::OCNT_W-1:0]     count
);

  logic [srlq_pkg::ID_W-1:0]     ids [srlq_pkg::OWNER_SLOTS];
  logic [srlq_pkg::OWNER_SLOTS-1:0] valid;
  logic [srlq_pkg::OIDX_W-1:0]   free_idx;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = srlq_pkg::OWNER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = srlq_pkg::OIDX_W'(i);
    end
  end

  // one slot compared per cycle
  assign scan_hit = valid[scan_idx] && (ids[scan_idx] == scan_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      if (cmd.remove) valid[cmd.rm_idx] <= 1'b0;
      if (cmd.add) valid[free_idx] <= 1'b1;
      count <= count + srlq_pkg::OCNT_W'(cmd.add) - srlq_pkg::OCNT_W'(cmd.remove);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) ids[free_idx] <= cmd.add_id;
  end

endmodule

>>> rtl/srlq_waitq.sv
// Waiter FIFO: circular store of (exclusive, id) entries.
// Depends on srlq_pkg.
module srlq_waitq (
  input  logic                          clk,
  input  logic                          rst,
  input  srlq_pkg::wq_cmd_t             cmd,
  output srlq_pkg::waiter_t             head_entry,
  output logic [srlq_pkg::WCNT_W-1:0]   count
);

  srlq_pkg::waiter_t             entries [srlq_pkg::WAITER_SLOTS];
  logic [srlq_pkg::WIDX_W-1:0]   head;
  logic [srlq_pkg::WIDX_W-1:0]   tail;

  assign head_entry = entries[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == srlq_pkg::WIDX_W'(srlq_pkg::WAITER_SLOTS - 1)) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == srlq_pkg::WIDX_W'(srlq_pkg::WAITER_SLOTS - 1)) ? '0 : head + 1'b1;
      end
      count <= count + srlq_pkg::WCNT_W'(cmd.push) - srlq_pkg::WCNT_W'(cmd.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) entries[tail] <= cmd.push_entry;
  end

endmodule

>>> rtl/shared_exclusive_row_lock_queue_top.sv
// Lock unit for one row: sequencer over the owner set and the waiter FIFO.
// Acquire or deterministic recon release: decide, then flush the result beat.
// Release: decide, an owner scan over up to OWNER_SLOTS slots (one compare per
// cycle), free the slot, then a wake per woken waiter and a flush to close.
// One request at a time; the next is taken once the last beat is registered.
// Synchronous active-high reset: no lock held, owners and waiters empty.
module shared_exclusive_row_lock_queue_top (
  input logic       clk,
  input logic       rst,
  srlq_req_if.sink  req,
  srlq_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FREE   = 3'd3;
  localparam logic [2:0] S_WAKE   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] held, held_next;
  logic [srlq_pkg::OIDX_W-1:0] scan_idx, scan_next;
  logic [srlq_pkg::WAKE_W-1:0] wakes, wakes_next;

  // latched request
  logic                       r_func, r_ex, r_kind, r_recon;
  logic [srlq_pkg::ID_W-1:0]  r_id;

  // pending result (last flag decided when the next one appears)
  logic                       pend_v, pend_v_next;
  logic [2:0]                 pend_st, pend_st_next;
  logic [srlq_pkg::ID_W-1:0]  pend_id, pend_id_next;
  logic                       pend_ex, pend_ex_next;

  // output register
  logic                       ov, ov_next;
  logic [2:0]                 o_st, o_st_next;
  logic [srlq_pkg::ID_W-1:0]  o_id, o_id_next;
  logic                       o_ex, o_ex_next;
  logic                       o_last, o_last_next;

  srlq_pkg::own_cmd_t ocmd;
  srlq_pkg::wq_cmd_t  wcmd;
  logic                          scan_hit;
  logic [srlq_pkg::OCNT_W-1:0]   ocnt;
  srlq_pkg::waiter_t             whead;
  logic [srlq_pkg::WCNT_W-1:0]   wcnt;

  logic can_emit, conflict, wake_ok;

  srlq_owner u_owner (
    .clk(clk), .rst(rst), .cmd(ocmd), .scan_idx(scan_idx), .scan_id(r_id),
    .scan_hit(scan_hit), .count(ocnt)
  );

  srlq_waitq u_waitq (
    .clk(clk), .rst(rst), .cmd(wcmd), .head_entry(whead), .count(wcnt)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ov;
  assign rsp.status = o_st;
  assign rsp.subject_txn = o_id;
  assign rsp.subject_exclusive = o_ex;
  assign rsp.last = o_last;

  assign can_emit = !ov || rsp.ready;
  assign conflict = srlq_pkg::mode_conflicts(held, r_ex) ||
                    ((r_kind == srlq_pkg::KIND_DET) && (wcnt != '0));
  assign wake_ok = (wcnt != '0) && (ocnt < srlq_pkg::OCNT_W'(srlq_pkg::OWNER_SLOTS)) &&
                   (wakes < srlq_pkg::WAKE_W'(srlq_pkg::MAX_WAKES)) &&
                   !srlq_pkg::mode_conflicts(held, whead.ex);

  // sequencer
  always_comb begin
    state_next   = state;
    held_next    = held;
    scan_next    = scan_idx;
    wakes_next   = wakes;
    pend_v_next  = pend_v;
    pend_st_next = pend_st;
    pend_id_next = pend_id;
    pend_ex_next = pend_ex;
    ov_next      = ov && !rsp.ready;
    o_st_next    = o_st;
    o_id_next    = o_id;
    o_ex_next    = o_ex;
    o_last_next  = o_last;
    ocmd         = '0;
    wcmd         = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_DECIDE;
          scan_next  = '0;
          wakes_next = '0;
        end
      end
      S_DECIDE: begin
        pend_id_next = r_id;
        if (r_func == srlq_pkg::FN_ACQUIRE) begin
          pend_v_next  = 1'b1;
          pend_ex_next = r_ex;
          state_next   = S_FLUSH;
          if (conflict) begin
            if (r_kind == srlq_pkg::KIND_DET) begin
              if (wcnt >= srlq_pkg::WCNT_W'(srlq_pkg::WAITER_SLOTS)) begin
                pend_st_next = srlq_pkg::ST_FULL;
              end else begin
                wcmd.push          = 1'b1;
                wcmd.push_entry.ex = r_ex;
                wcmd.push_entry.id = r_id;
                pend_st_next       = srlq_pkg::ST_WAIT;
              end
            end else begin
              pend_st_next = srlq_pkg::ST_ABORT;
            end
          end else if (ocnt >= srlq_pkg::OCNT_W'(srlq_pkg::OWNER_SLOTS)) begin
            pend_st_next = srlq_pkg::ST_FULL;
          end else begin
            ocmd.add     = 1'b1;
            ocmd.add_id  = r_id;
            held_next    = r_ex ? srlq_pkg::MODE_EXCL : srlq_pkg::MODE_SHARED;
            pend_st_next = srlq_pkg::ST_GRANTED;
          end
        end else if (r_recon && (r_kind == srlq_pkg::KIND_DET)) begin
          pend_v_next  = 1'b1;
          pend_st_next = srlq_pkg::ST_RELEASED;
          pend_ex_next = 1'b0;
          state_next   = S_FLUSH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_FREE;
        end else if (scan_idx == srlq_pkg::OIDX_W'(srlq_pkg::OWNER_SLOTS - 1)) begin
          pend_v_next  = 1'b1;
          pend_st_next = srlq_pkg::ST_NOT_OWN;
          pend_ex_next = 1'b0;
          state_next   = S_FLUSH;
        end else begin
          scan_next = scan_idx + 1'b1;
        end
      end
      S_FREE: begin
        ocmd.remove  = 1'b1;
        ocmd.rm_idx  = scan_idx;
        if (ocnt == srlq_pkg::OCNT_W'(1)) held_next = srlq_pkg::MODE_NONE;
        pend_v_next  = 1'b1;
        pend_st_next = srlq_pkg::ST_RELEASED;
        pend_ex_next = 1'b0;
        state_next   = S_WAKE;
      end
      S_WAKE: begin
        if (!wake_ok) begin
          state_next = S_FLUSH;
        end else if (can_emit) begin
          // previous result is not the last one
          ov_next      = 1'b1;
          o_st_next    = pend_st;
          o_id_next    = pend_id;
          o_ex_next    = pend_ex;
          o_last_next  = 1'b0;
          wcmd.pop     = 1'b1;
          ocmd.add     = 1'b1;
          ocmd.add_id  = whead.id;
          held_next    = whead.ex ? srlq_pkg::MODE_EXCL : srlq_pkg::MODE_SHARED;
          pend_st_next = srlq_pkg::ST_WOKEN;
          pend_id_next = whead.id;
          pend_ex_next = whead.ex;
          wakes_next   = wakes + 1'b1;
        end
      end
      S_FLUSH: begin
        if (can_emit) begin
          ov_next     = 1'b1;
          o_st_next   = pend_st;
          o_id_next   = pend_id;
          o_ex_next   = pend_ex;
          o_last_next = 1'b1;
          pend_v_next = 1'b0;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      held   <= srlq_pkg::MODE_NONE;
      pend_v <= 1'b0;
      ov     <= 1'b0;
      wakes  <= '0;
    end else begin
      state  <= state_next;
      held   <= held_next;
      pend_v <= pend_v_next;
      ov     <= ov_next;
      wakes  <= wakes_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx <= scan_next;
    pend_st  <= pend_st_next;
    pend_id  <= pend_id_next;
    pend_ex  <= pend_ex_next;
    o_st     <= o_st_next;
    o_id     <= o_id_next;
    o_ex     <= o_ex_next;
    o_last   <= o_last_next;
    if (req.valid && req.ready) begin
      r_func  <= req.func;
      r_id    <= req.txn_id;
      r_ex    <= req.want_exclusive;
      r_kind  <= req.requester_kind;
      r_recon <= req.is_recon;
    end
  end

`ifndef SYNTHESIS
  a_owner_bound: assert property (@(posedge clk) disable iff (rst)
    ocnt <= srlq_pkg::OCNT_W'(srlq_pkg::OWNER_SLOTS))
    else $error("owner count over capacity");
  a_waiter_bound: assert property (@(posedge clk) disable iff (rst)
    wcnt <= srlq_pkg::WCNT_W'(srlq_pkg::WAITER_SLOTS))
    else $error("waiter count over capacity");
  a_held_matches_owners: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((ocnt == '0) == (held == srlq_pkg::MODE_NONE)))
    else $error("held mode disagrees with owner count");
  a_wake_bound: assert property (@(posedge clk) disable iff (rst)
    wakes <= srlq_pkg::WAKE_W'(srlq_pkg::MAX_WAKES))
    else $error("too many wakes for one release");
`endif

endmodule
